[hdl/adaptive_garbage_collection_trigger_top_defines.svh]
// assertion macros for the garbage collection trigger
`ifndef ADAPTIVE_GARBAGE_COLLECTION_TRIGGER_TOP_DEFINES_SVH
`define ADAPTIVE_GARBAGE_COLLECTION_TRIGGER_TOP_DEFINES_SVH

// same-cycle implication
`define AGCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AGCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/agct_pkg.sv]
// shared types and constants of the garbage collection trigger
package agct_pkg;

	localparam int unsigned AW = 64;          // multiplicand width
	localparam int unsigned BW = 48;          // multiplier width
	localparam int unsigned PW = AW + BW;     // product width
	localparam int unsigned DW = 55;          // divisor width
	localparam int unsigned QW = 61;          // capped quotient width
	localparam int unsigned CW = 7;           // step counter width
	localparam logic [CW-1:0] MulLast = CW'(BW - 1);
	localparam logic [CW-1:0] DivLast = CW'(PW - 1);
	localparam logic [QW-1:0] QCap = QW'(1) << 60;

	localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] M32 = 32'hFFFF_FFFF;

	localparam logic [47:0] SplitRst = 48'd268435456;
	localparam logic [47:0] DataGoalRst = 48'(268435456 / 10);
	localparam logic [47:0] DataMinRst = 48'((268435456 / 10) / 2);
	localparam logic [6:0]  ThrRst = 7'd20;
	localparam logic [31:0] StartRst = 32'd1;

	typedef enum logic [2:0] {
		CFG_THRESHOLD = 3'd0,
		CFG_SPLIT     = 3'd1,
		CFG_VERLIMIT  = 3'd2,
		CFG_TTL       = 3'd3,
		CFG_MEMRES    = 3'd4,
		CFG_START     = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_ADD    = 3'd1,
		KIND_FINISH = 3'd2,
		KIND_CHECK  = 3'd3,
		KIND_ADJUST = 3'd4
	} kind_t;

	typedef struct packed {
		logic [6:0]  thr;
		logic        hvl;
		logic [31:0] ttl;
		logic        mres;
	} cfg_t;

	// goals keep the full capped quotient, results show the low bits
	typedef struct packed {
		logic [QW-1:0] data_goal;
		logic [QW-1:0] time_goal;
		logic [31:0] lct;
		logic [47:0] lcd;
		logic [47:0] disk;
		logic [31:0] dels;
		logic [47:0] expb;
	} sums_t;

	typedef struct packed {
		logic [31:0] now;
		logic [47:0] cb;
		logic [31:0] cd;
	} probe_t;

	typedef struct packed {
		logic        gp;
		logic        cdl;
		logic        ctt;
		logic        check;
		logic [48:0] accum;
		logic [32:0] el;
	} rules_t;

	typedef struct packed {
		logic [AW-1:0] a;
		logic [BW-1:0] b;
		logic [DW-1:0] d;
	} mdu_op_t;

endpackage

[hdl/agct_mdu.sv]
// shared serial multiply then divide unit, quotient capped at 2^60
module agct_mdu (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  agct_pkg::mdu_op_t         op,
	output logic                      busy,
	output logic                      done,
	output logic [agct_pkg::QW-1:0]   res
);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_MUL  = 3'b010,
		M_DIV  = 3'b100
	} mstate_t;

	mstate_t                     state_q;
	logic [agct_pkg::CW-1:0]     cnt_q;
	logic [agct_pkg::PW-1:0]     prod_q;
	logic [agct_pkg::PW-1:0]     mcand_q;
	logic [agct_pkg::BW-1:0]     mplier_q;
	logic [agct_pkg::DW-1:0]     d_q;
	logic [agct_pkg::DW-1:0]     rem_q;
	logic [agct_pkg::QW-1:0]     quo_q;
	logic                        ovf_q;
	logic                        done_q;

	logic [agct_pkg::DW:0]       rem_n;
	logic                        ge;

	assign rem_n = {rem_q, prod_q[agct_pkg::PW-1]};
	assign ge    = rem_n >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_MUL;
						cnt_q   <= '0;
					end
				end
				M_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == agct_pkg::MulLast) begin
						state_q <= M_DIV;
						cnt_q   <= '0;
					end
				end
				M_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == agct_pkg::DivLast) begin
						state_q <= M_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			prod_q   <= '0;
			mcand_q  <= {{agct_pkg::BW{1'b0}}, op.a};
			mplier_q <= op.b;
			d_q      <= op.d;
		end else if (state_q == M_MUL) begin
			if (mplier_q[0])
				prod_q <= prod_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			rem_q    <= '0;
			quo_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (state_q == M_DIV) begin
			rem_q  <= ge ? agct_pkg::DW'(rem_n - {1'b0, d_q}) : agct_pkg::DW'(rem_n);
			prod_q <= prod_q << 1;
			ovf_q  <= ovf_q | quo_q[agct_pkg::QW-1];
			quo_q  <= {quo_q[agct_pkg::QW-2:0], ge};
		end
	end

	assign busy = state_q != M_IDLE;
	assign done = done_q;
	assign res  = (ovf_q || quo_q > agct_pkg::QCap) ? agct_pkg::QCap : quo_q;

endmodule

[hdl/agct_rules.sv]
// deletes rule, ttl rule and check answer from the current state
module agct_rules (
	input  agct_pkg::cfg_t    cfg,
	input  agct_pkg::sums_t   st,
	input  agct_pkg::probe_t  pr,
	output agct_pkg::rules_t  r
);

	logic [47:0] mem;
	logic [47:0] disk_gain;
	logic [48:0] tot;
	logic [48:0] pos;
	logic [55:0] pos100;
	logic [55:0] thr_tot;
	logic        at;
	logic [32:0] el;
	logic        el_ge;

	always_comb begin
		if (cfg.mres)
			mem = (pr.cb > st.lcd) ? pr.cb - st.lcd : '0;
		else
			mem = pr.cb;
		disk_gain = (st.disk > st.lcd) ? st.disk - st.lcd : '0;
		tot       = {1'b0, st.disk} + {1'b0, mem};
		pos       = {1'b0, st.expb} + {1'b0, mem};
		pos100    = 56'(pos) * 56'd100;
		thr_tot   = 56'(tot) * 56'(cfg.thr);
		at        = (tot == '0) ? (cfg.thr == '0) : (pos100 >= thr_tot);
		el        = {1'b0, pr.now} - {1'b0, st.lct};
		// negative elapsed time never reaches the goal
		el_ge     = !el[32] && (agct_pkg::QW'(el[31:0]) >= st.time_goal);

		r.accum = {1'b0, mem} + {1'b0, disk_gain};
		r.el    = el;
		r.gp    = cfg.hvl || (st.dels != '0) || (pr.cd != '0);
		r.cdl   = r.gp && (agct_pkg::QW'(r.accum) >= st.data_goal);
		r.ctt   = (cfg.ttl != '0) && at && el_ge;
		r.check = (st.lct != '0) && (r.cdl || r.ctt);
	end

endmodule

[hdl/adaptive_garbage_collection_trigger_top.sv]
// top level of the adaptive garbage collection trigger
//
// channel  direction  handshake          content
// s_*      in         tvalid/tready      one item word, kind in tuser
// m_*      out        tvalid/tready      one result word on check and adjust
// cfg_*    in         write enable only  register index and data
//
// clear, add and finish items stay in idle; a check goes through eval, pick and final states
// an adjust that retunes runs the shared multiply-divide unit once per ratio, plus
// once more for the 115 percent scale when no collection is needed
// writing split_size or shortest_ttl divides by ten on the same unit,
// with the input not ready; reset values load directly, no clearing pass
// a result waiting on the output holds the sequencer, and intake, only once the next is ready
module adaptive_garbage_collection_trigger_top (
	input  logic         clk,
	input  logic         arst_n,
	// item in
	input  logic         s_tvalid,
	output logic         s_tready,
	// now, collection_done, store_expirable, store_deletes, store_logical_bytes,
	// cache_bytes, cache_deletes, cache_full_bytes, scan_in_bytes,
	// scan_out_bytes, scan_kept_deletes, zero pad
	input  logic [391:0] s_tdata,
	// kind
	input  logic [2:0]   s_tuser,
	// result out
	output logic         m_tvalid,
	input  logic         m_tready,
	// collect_needed, data_target, time_target, zero pad
	output logic [87:0]  m_tdata,
	// configuration writes
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [47:0]  cfg_data
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_CDIV = 7'b0000010,
		S_EVAL = 7'b0000100,
		S_PICK = 7'b0001000,
		S_RAT  = 7'b0010000,
		S_SCL  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	// input word fields
	logic [31:0] in_now;
	logic        in_done;
	logic [47:0] in_exp;
	logic [31:0] in_del;
	logic [47:0] in_lb;
	logic [47:0] in_cb;
	logic [31:0] in_cd;
	logic [47:0] in_cfb;
	logic [47:0] in_sin;
	logic [47:0] in_sout;
	logic        in_kept;

	assign in_now  = s_tdata[31:0];
	assign in_done = s_tdata[32];
	assign in_exp  = s_tdata[80:33];
	assign in_del  = s_tdata[112:81];
	assign in_lb   = s_tdata[160:113];
	assign in_cb   = s_tdata[208:161];
	assign in_cd   = s_tdata[240:209];
	assign in_cfb  = s_tdata[288:241];
	assign in_sin  = s_tdata[336:289];
	assign in_sout = s_tdata[384:337];
	assign in_kept = s_tdata[385];

	state_t            state_q;
	agct_pkg::cfg_t    cfg_q;
	agct_pkg::sums_t   st_q;
	logic [47:0]       split_q;
	logic [47:0]       data_min_q;
	logic [31:0]       time_min_q;
	logic              split_pend_q;
	logic              ttl_pend_q;
	logic              cdiv_ttl_q;     // running divide is for the ttl

	// latched check or adjust item
	agct_pkg::probe_t  pr_q;
	logic              adj_q;
	logic              kept_q;
	logic [47:0]       tin_q;
	logic [47:0]       tout_q;

	// retune job
	logic              dpend_q;
	logic              tpend_q;
	logic              tgt_q;          // 0 data goal, 1 time goal
	logic              needed_q;
	logic              pos_q;
	logic [48:0]       accum_q;
	logic [32:0]       el_q;

	logic              m_tvalid_q;
	logic [87:0]       m_tdata_q;

	agct_pkg::rules_t  rules;
	agct_pkg::mdu_op_t mop;
	logic              mstart;
	logic              mbusy;
	logic              mdone;
	logic [agct_pkg::QW-1:0] mres;

	logic              accept;
	logic              needed_c;
	logic              adj_go;
	logic [47:0]       gar;
	logic [54:0]       gar100;
	logic [54:0]       thr_in;
	logic [67:0]       scaled;
	logic              tsel;           // goal being worked on, 1 time goal
	logic [61:0]       goal_c;
	logic [61:0]       dbl_c;
	logic [61:0]       sat_c;
	logic [61:0]       min_c;
	logic [61:0]       new_c;
	logic              wr_split;
	logic              wr_ttl;

	function automatic logic [47:0] sat48(input logic [47:0] x, input logic [47:0] y);
		logic [48:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[48] ? agct_pkg::M48 : s[47:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [31:0] x, input logic [31:0] y);
		logic [32:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[32] ? agct_pkg::M32 : s[31:0];
	endfunction

	// nonblocking goal write from inside the clocked block
	task automatic put_goal(input logic [61:0] v);
		if (tgt_q)
			st_q.time_goal <= v[agct_pkg::QW-1:0];
		else
			st_q.data_goal <= v[agct_pkg::QW-1:0];
	endtask

	agct_rules u_rules (
		.cfg (cfg_q),
		.st  (st_q),
		.pr  (pr_q),
		.r   (rules)
	);

	agct_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mstart),
		.op     (mop),
		.busy   (mbusy),
		.done   (mdone),
		.res    (mres)
	);

	assign s_tready = (state_q == S_IDLE) && !split_pend_q && !ttl_pend_q;
	assign accept   = s_tvalid && s_tready;
	assign wr_split = cfg_we && (cfg_index == agct_pkg::CFG_SPLIT);
	assign wr_ttl   = cfg_we && (cfg_index == agct_pkg::CFG_TTL);

	// scan garbage ratio against threshold
	always_comb begin
		gar      = tin_q - tout_q;
		gar100   = 55'(gar) * 55'd100;
		thr_in   = 55'(tin_q) * 55'(cfg_q.thr);
		if (tin_q == '0)
			needed_c = cfg_q.thr == '0;
		else if (tin_q < tout_q)
			needed_c = 1'b0;
		else
			needed_c = gar100 >= thr_in;
		adj_go = adj_q && !kept_q && (st_q.lct != '0) && (needed_c != (rules.cdl || rules.ctt));
	end

	// goal update from a finished quotient, or plain doubling while picking
	always_comb begin
		scaled = 68'(mres) * 68'd115;
		tsel   = (state_q == S_PICK) ? !dpend_q : tgt_q;
		goal_c = tsel ? 62'(st_q.time_goal) : 62'(st_q.data_goal);
		min_c  = tsel ? 62'(time_min_q) : 62'(data_min_q);
		dbl_c  = goal_c << 1;
		if (tsel)
			sat_c = (dbl_c > 62'(agct_pkg::M32)) ? 62'(agct_pkg::M32) : dbl_c;
		else
			sat_c = (dbl_c > 62'(agct_pkg::M48)) ? 62'(agct_pkg::M48) : dbl_c;
		if (62'(mres) < min_c)
			new_c = min_c;
		else if (62'(mres) > dbl_c)
			new_c = sat_c;
		else
			new_c = 62'(mres);
	end

	// shared unit launch
	always_comb begin
		mstart = 1'b0;
		mop.a  = '0;
		mop.b  = 48'd1;
		mop.d  = 55'd10;
		unique case (state_q)
			S_IDLE: begin
				if (split_pend_q || ttl_pend_q) begin
					mstart = 1'b1;
					mop.a  = split_pend_q ? 64'(split_q) : 64'(cfg_q.ttl);
				end
			end
			S_PICK: begin
				mop.b = tin_q;
				mop.d = gar100;
				if (dpend_q) begin
					mstart = pos_q;
					mop.a  = 64'(accum_q) * 64'(cfg_q.thr);
				end else if (tpend_q) begin
					mstart = pos_q && !el_q[32];
					mop.a  = 64'(el_q[31:0]) * 64'(cfg_q.thr);
				end
			end
			S_RAT: begin
				if (mdone && !needed_q) begin
					mstart = 1'b1;
					mop.a  = scaled[63:0];
					mop.d  = 55'd100;
				end
			end
			default: mstart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cfg_q.thr    <= agct_pkg::ThrRst;
			cfg_q.hvl    <= 1'b0;
			cfg_q.ttl    <= '0;
			cfg_q.mres   <= 1'b0;
			split_q      <= agct_pkg::SplitRst;
			st_q.data_goal <= agct_pkg::QW'(agct_pkg::DataGoalRst);
			st_q.time_goal <= '0;
			st_q.lct     <= agct_pkg::StartRst;
			st_q.lcd     <= '0;
			st_q.disk    <= '0;
			st_q.dels    <= '0;
			st_q.expb    <= '0;
			data_min_q   <= agct_pkg::DataMinRst;
			time_min_q   <= '0;
			split_pend_q <= 1'b0;
			ttl_pend_q   <= 1'b0;
			cdiv_ttl_q   <= 1'b0;
			dpend_q      <= 1'b0;
			tpend_q      <= 1'b0;
			tgt_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// the final state reloads the output itself
			if (m_tvalid_q && m_tready && state_q != S_FIN)
				m_tvalid_q <= 1'b0;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					agct_pkg::CFG_THRESHOLD: cfg_q.thr  <= cfg_data[6:0];
					agct_pkg::CFG_SPLIT:     split_q    <= cfg_data;
					agct_pkg::CFG_VERLIMIT:  cfg_q.hvl  <= cfg_data[0];
					agct_pkg::CFG_TTL:       cfg_q.ttl  <= cfg_data[31:0];
					agct_pkg::CFG_MEMRES:    cfg_q.mres <= cfg_data[0];
					agct_pkg::CFG_START:     st_q.lct   <= cfg_data[31:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (split_pend_q || ttl_pend_q) begin
						cdiv_ttl_q <= !split_pend_q;
						state_q    <= S_CDIV;
					end else if (accept) begin
						case (s_tuser) inside
							agct_pkg::KIND_CLEAR: begin
								st_q.disk <= '0;
								st_q.dels <= '0;
								st_q.expb <= '0;
							end
							agct_pkg::KIND_ADD: begin
								st_q.expb <= sat48(st_q.expb, in_exp);
								st_q.dels <= sat32(st_q.dels, in_del);
								st_q.disk <= sat48(st_q.disk, in_lb);
							end
							agct_pkg::KIND_FINISH: begin
								if (cfg_q.mres)
									st_q.disk <= in_cfb;
								if (in_done) begin
									st_q.lct <= in_now;
									st_q.lcd <= cfg_q.mres ? in_cfb : st_q.disk;
								end
							end
							agct_pkg::KIND_CHECK, agct_pkg::KIND_ADJUST: begin
								adj_q   <= s_tuser == agct_pkg::KIND_ADJUST;
								state_q <= S_EVAL;
							end
							default: ;
						endcase
					end
				end
				S_CDIV: begin
					if (mdone) begin
						if (cdiv_ttl_q) begin
							st_q.time_goal <= agct_pkg::QW'(mres[31:0]);
							time_min_q     <= mres[31:0];
						end else begin
							st_q.data_goal <= agct_pkg::QW'(mres[47:0]);
							data_min_q     <= mres[48:1];
						end
						state_q <= S_IDLE;
					end
				end
				S_EVAL: begin
					needed_q <= needed_c;
					pos_q    <= (tin_q != '0) && (tin_q > tout_q);
					accum_q  <= rules.accum;
					el_q     <= rules.el;
					dpend_q  <= adj_go && rules.gp && (rules.cdl != needed_c);
					tpend_q  <= adj_go && (cfg_q.ttl != '0) && (rules.ctt != needed_c);
					state_q  <= S_PICK;
				end
				S_PICK: begin
					if (dpend_q) begin
						dpend_q <= 1'b0;
						tgt_q   <= 1'b0;
						if (pos_q)
							state_q <= S_RAT;
						else
							st_q.data_goal <= sat_c[agct_pkg::QW-1:0];
					end else if (tpend_q) begin
						tpend_q <= 1'b0;
						tgt_q   <= 1'b1;
						if (!pos_q)
							st_q.time_goal <= sat_c[agct_pkg::QW-1:0];
						else if (el_q[32])
							st_q.time_goal <= agct_pkg::QW'(time_min_q);
						else
							state_q <= S_RAT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RAT: begin
					if (mdone) begin
						if (needed_q) begin
							put_goal(new_c);
							state_q <= S_PICK;
						end else begin
							state_q <= S_SCL;
						end
					end
				end
				S_SCL: begin
					if (mdone) begin
						put_goal(new_c);
						state_q <= S_PICK;
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// pending divide by ten; a fresh write restarts it
			if (wr_split)
				split_pend_q <= 1'b1;
			else if (state_q == S_CDIV && mdone && !cdiv_ttl_q)
				split_pend_q <= 1'b0;
			if (wr_ttl)
				ttl_pend_q <= 1'b1;
			else if (state_q == S_CDIV && mdone && cdiv_ttl_q)
				ttl_pend_q <= 1'b0;
		end
	end

	// item and result payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			pr_q.now <= in_now;
			pr_q.cb  <= in_cb;
			pr_q.cd  <= in_cd;
			kept_q   <= in_kept;
			tin_q    <= in_sin;
			tout_q   <= in_sout;
		end
		if (state_q == S_FIN && (!m_tvalid_q || m_tready))
			m_tdata_q <= {7'b0, st_q.time_goal[31:0], st_q.data_goal[47:0], rules.check};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`include "adaptive_garbage_collection_trigger_top_defines.svh"

	// the shared unit never runs while items are taken
	`AGCT_ASSERT_NOW(a_busy_not_ready, mbusy, !s_tready, "input ready while unit busy")
	// a result appears only out of the final state
	`AGCT_ASSERT_NOW(a_result_src, $rose(m_tvalid), $past(state_q == S_FIN), "result without final state")
	// retune jobs live only inside the adjust sequence
	`AGCT_ASSERT_NOW(a_job_scope, dpend_q || tpend_q, state_q == S_PICK || state_q == S_RAT || state_q == S_SCL, "retune job pending outside adjust")

endmodule

[sim/tb_top.sv]
// self-checking testbench of the adaptive garbage collection trigger
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// one input word, unpacked for readability
	typedef struct {
		logic [2:0]  kind;
		logic [31:0] now;
		logic        done;
		logic [47:0] st_exp;
		logic [31:0] st_dels;
		logic [47:0] st_bytes;
		logic [47:0] cbytes;
		logic [31:0] cdels;
		logic [47:0] cfull;
		logic [47:0] scan_in;
		logic [47:0] scan_out;
		logic        kept;
	} gc_item_t;

	typedef struct {
		logic        needed;
		logic [47:0] data_tgt;
		logic [31:0] time_tgt;
	} gc_verdict_t;

	// predictor of the trigger plus the queue of verdicts still owed
	class gc_scoreboard;
		bit [63:0] thr, split, hvl, ttl, mres, start;
		bit [63:0] data_goal, time_goal, lct, lcd, disk, dels, expb;
		gc_verdict_t owed[$];
		int errors;

		function new();
			thr = 20; split = 268435456; hvl = 0; ttl = 0; mres = 0; start = 1;
			data_goal = split / 10; time_goal = 0; lct = start;
			lcd = 0; disk = 0; dels = 0; expb = 0;
			errors = 0;
		endfunction

		function void write_reg(agct_pkg::cfg_idx_t idx, bit [47:0] v);
			case (idx)
				agct_pkg::CFG_THRESHOLD: thr = v[6:0];
				agct_pkg::CFG_SPLIT: begin
					split = v; data_goal = split / 10;
				end
				agct_pkg::CFG_VERLIMIT: hvl = v[0];
				agct_pkg::CFG_TTL: begin
					ttl = v[31:0]; time_goal = ttl / 10;
				end
				agct_pkg::CFG_MEMRES: mres = v[0];
				agct_pkg::CFG_START: begin
					start = v[31:0]; lct = start;
				end
				default: ;
			endcase
		endfunction

		function bit [63:0] sat(bit [63:0] s, bit [63:0] mask);
			return s > mask ? mask : s;
		endfunction

		function bit [63:0] mem_part(bit [63:0] cb);
			if (mres)
				return cb > lcd ? cb - lcd : 0;
			return cb;
		endfunction

		function bit [63:0] accum(bit [63:0] cb);
			bit [63:0] a;
			a = mem_part(cb);
			if (disk > lcd)
				a += disk - lcd;
			return a;
		endfunction

		function bit gc_possible(bit [63:0] cd);
			return hvl != 0 || dels + cd > 0;
		endfunction

		function bit deletes_rule(bit [63:0] cb, bit [63:0] cd);
			return gc_possible(cd) && accum(cb) >= data_goal;
		endfunction

		function longint elapsed(bit [63:0] now);
			return longint'(now) - longint'(lct);
		endfunction

		function bit ttl_rule(bit [63:0] cb, bit [63:0] now);
			bit [63:0] m, tot, pos;
			bit at;
			m = mem_part(cb);
			tot = disk + m;
			pos = expb + m;
			at = (tot == 0) ? (thr == 0) : (pos * 100 >= thr * tot);
			return ttl > 0 && at && elapsed(now) >= longint'(time_goal);
		endfunction

		// new goal from the real garbage ratio of a scan
		function bit [63:0] rescale(bit [63:0] goal, bit [63:0] minv, bit [63:0] base,
				bit needed, bit [63:0] tin, bit [63:0] garb, bit [63:0] mask);
			bit [127:0] num, quo;
			bit [63:0] n;
			num = 128'(base * thr) * 128'(tin);
			quo = num / (128'(garb) * 128'd100);
			n = quo > 128'(64'd1 << 60) ? (64'd1 << 60) : quo[63:0];
			if (!needed)
				n = n * 115 / 100;
			if (n < minv)
				return minv;
			if (n > goal * 2)
				return sat(goal * 2, mask);
			return n;
		endfunction

		function void note_item(gc_item_t it);
			bit [63:0] cb, cd, now, tin, tout, acc;
			longint g, el;
			bit needed, positive, cdl, ctt;
			gc_verdict_t v;
			cb = it.cbytes; cd = it.cdels; now = it.now;
			case (it.kind)
				agct_pkg::KIND_CLEAR: begin
					disk = 0; dels = 0; expb = 0;
					return;
				end
				agct_pkg::KIND_ADD: begin
					expb = sat(expb + it.st_exp, 64'(agct_pkg::M48));
					dels = sat(dels + it.st_dels, 64'(agct_pkg::M32));
					disk = sat(disk + it.st_bytes, 64'(agct_pkg::M48));
					return;
				end
				agct_pkg::KIND_FINISH: begin
					if (mres)
						disk = it.cfull;
					if (it.done) begin
						lct = now; lcd = disk;
					end
					return;
				end
				agct_pkg::KIND_CHECK: ;
				agct_pkg::KIND_ADJUST: begin
					if (!it.kept && lct != 0) begin
						tin = it.scan_in; tout = it.scan_out;
						g = longint'(tin) - longint'(tout);
						needed = (tin == 0) ? (thr == 0) : (g * 100 >= longint'(thr * tin));
						positive = tin != 0 && g > 0;
						cdl = deletes_rule(cb, cd);
						ctt = ttl_rule(cb, now);
						acc = accum(cb);
						el = elapsed(now);
						if (needed != (cdl || ctt)) begin
							if (gc_possible(cd) && cdl != needed)
								data_goal = positive ?
									rescale(data_goal, (split / 10) / 2, acc, needed,
										tin, 64'(g), 64'(agct_pkg::M48)) :
									sat(data_goal * 2, 64'(agct_pkg::M48));
							if (ttl > 0 && ctt != needed) begin
								if (!positive)
									time_goal = sat(time_goal * 2, 64'(agct_pkg::M32));
								else if (el < 0)
									time_goal = ttl / 10;
								else
									time_goal = rescale(time_goal, ttl / 10, 64'(el),
										needed, tin, 64'(g), 64'(agct_pkg::M32));
							end
						end
					end
				end
				default: return;
			endcase
			v.needed = lct != 0 && (deletes_rule(cb, cd) || ttl_rule(cb, now));
			v.data_tgt = data_goal[47:0];
			v.time_tgt = time_goal[31:0];
			owed.push_back(v);
		endfunction

		function void check_result(logic [87:0] d);
			gc_verdict_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result word %h", $realtime, d);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (d[0] !== e.needed) begin
				$display("%0t: collect_needed expected %0d actual %0d", $realtime,
					e.needed, d[0]);
				errors++;
			end
			if (d[48:1] !== e.data_tgt) begin
				$display("%0t: data_target expected %0d actual %0d", $realtime,
					e.data_tgt, d[48:1]);
				errors++;
			end
			if (d[80:49] !== e.time_tgt) begin
				$display("%0t: time_target expected %0d actual %0d", $realtime,
					e.time_tgt, d[80:49]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [391:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [87:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [47:0]  cfg_data = '0;

	gc_scoreboard sb = new();
	int idle_pct = 0;      // sender gap chance per word
	int stall_pct = 0;     // receiver stall chance per cycle
	bit hold_req = 0;      // ask the receiver for one long hold-off
	bit hold_done = 0;
	int hold_left = 0;
	longint cycles = 0;

	adaptive_garbage_collection_trigger_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog, far above the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 6000000) begin
			$display("** adaptive_garbage_collection_trigger_top: FAILED **");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request, check every word
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// 48-bit value: mostly small, sometimes extreme or fully random
	function automatic logic [47:0] rnd48(int small_max);
		case ($urandom_range(0, 9))
			0: return 48'({$urandom, $urandom});
			1: return agct_pkg::M48;
			2: return '0;
			default: return 48'($urandom_range(0, small_max));
		endcase
	endfunction

	function automatic logic [31:0] rnd32(int small_max);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return agct_pkg::M32;
			2: return '0;
			default: return 32'($urandom_range(0, small_max));
		endcase
	endfunction

	function automatic gc_item_t rnd_item();
		gc_item_t it;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) it.kind = agct_pkg::KIND_ADD;
		else if (r < 55) it.kind = agct_pkg::KIND_CHECK;
		else if (r < 77) it.kind = agct_pkg::KIND_ADJUST;
		else if (r < 89) it.kind = agct_pkg::KIND_FINISH;
		else if (r < 96) it.kind = agct_pkg::KIND_CLEAR;
		else it.kind = 3'($urandom_range(5, 7));  // ignored kinds
		it.now = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3000));
		it.done = 1'($urandom_range(0, 1));
		it.st_exp = rnd48(20000);
		it.st_dels = rnd32(3);
		it.st_bytes = rnd48(40000);
		it.cbytes = rnd48(40000);
		it.cdels = rnd32(2);
		it.cfull = rnd48(80000);
		it.scan_in = rnd48(100000);
		// mostly out below in so the ratio is a real garbage fraction
		it.scan_out = ($urandom_range(0, 3) == 0) ? rnd48(100000) :
			48'($urandom_range(0, 100)) * (it.scan_in / 100);
		it.kept = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	// offer one word, note it on acceptance, then maybe leave a gap
	task automatic send_word(gc_item_t it);
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {6'd0, it.kept, it.scan_out, it.scan_in, it.cfull, it.cdels,
			it.cbytes, it.st_bytes, it.st_dels, it.st_exp, it.done, it.now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(it);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	// stop offering, wait for all results, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (800)
			@(posedge clk);
	endtask

	task automatic write_reg(agct_pkg::cfg_idx_t idx, logic [47:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, v);
		// split and ttl writes keep the divider busy for a while
		@(posedge clk);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic setup(logic [6:0] thr, logic [47:0] split, logic hvl,
			logic [31:0] ttl, logic mres, logic [31:0] start);
		drain();
		write_reg(agct_pkg::CFG_THRESHOLD, 48'(thr));
		write_reg(agct_pkg::CFG_SPLIT, split);
		write_reg(agct_pkg::CFG_VERLIMIT, 48'(hvl));
		write_reg(agct_pkg::CFG_TTL, 48'(ttl));
		write_reg(agct_pkg::CFG_MEMRES, 48'(mres));
		write_reg(agct_pkg::CFG_START, 48'(start));
	endtask

	task automatic run_random(int n);
		repeat (n)
			send_word(rnd_item());
	endtask

	initial begin
		gc_item_t it;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset settings
		it = '{kind: agct_pkg::KIND_CHECK, default: '0};
		send_word(it);                                      // zero totals
		it = '{kind: agct_pkg::KIND_ADD, st_exp: agct_pkg::M48, st_dels: agct_pkg::M32,
			st_bytes: agct_pkg::M48, default: '0};
		send_word(it);
		send_word(it);                                      // sums saturate
		it = '{kind: agct_pkg::KIND_CHECK, now: agct_pkg::M32, cbytes: agct_pkg::M48,
			cdels: agct_pkg::M32, default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_ADJUST, now: 32'd50, scan_in: 48'd1000,
			scan_out: 48'd100, default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_ADJUST, now: 32'd50, scan_in: 48'd0, default: '0};
		send_word(it);                                      // zero scan total
		it = '{kind: agct_pkg::KIND_ADJUST, scan_in: 48'd10, scan_out: agct_pkg::M48,
			default: '0};
		send_word(it);                                      // out above in
		it = '{kind: agct_pkg::KIND_ADJUST, scan_in: agct_pkg::M48, scan_out: 48'd0,
			kept: 1'b1, default: '0};
		send_word(it);
		it = '{kind: 3'd5, default: '0};
		send_word(it);
		it = '{kind: 3'd7, now: agct_pkg::M32, default: '1};
		send_word(it);
		it = '{kind: agct_pkg::KIND_CLEAR, default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_FINISH, now: 32'd100, done: 1'b1, default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_ADJUST, now: 32'd10, scan_in: 48'd100,
			scan_out: 48'd0, default: '0};
		send_word(it);                                      // now before last collection

		// ttl rule live, negative elapsed and never collected
		setup(7'd0, 48'd0, 1'b1, agct_pkg::M32, 1'b1, 32'd0);
		it = '{kind: agct_pkg::KIND_ADJUST, now: 32'd5, scan_in: 48'd10, scan_out: 48'd1,
			default: '0};
		send_word(it);                                      // never collected
		it = '{kind: agct_pkg::KIND_FINISH, now: 32'd1000, done: 1'b1, cfull: 48'd500,
			default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_ADJUST, now: 32'd10, cbytes: 48'd700, scan_in: 48'd10,
			scan_out: 48'd1, default: '0};
		send_word(it);
		it = '{kind: agct_pkg::KIND_CHECK, now: agct_pkg::M32, cbytes: 48'd700,
			default: '0};
		send_word(it);

		// random phases across settings and idling modes
		setup(7'd20, 48'd50000, 1'b0, 32'd200, 1'b0, 32'd1);
		idle_pct = 0; stall_pct = 0;
		run_random(140);
		setup(7'd100, 48'd200000, 1'b1, 32'd30, 1'b1, 32'd400);
		idle_pct = 79; stall_pct = 0;
		run_random(130);
		setup(7'd0, agct_pkg::M48, 1'b0, agct_pkg::M32, 1'b0, agct_pkg::M32);
		idle_pct = 0; stall_pct = 79;
		run_random(130);
		setup(7'd50, 48'd10, 1'b1, 32'd1, 1'b0, 32'd1);
		idle_pct = 21; stall_pct = 21;
		run_random(130);
		// long receiver hold-off while words keep coming
		setup(7'd35, 48'd80000, 1'b0, 32'd500, 1'b1, 32'd100);
		idle_pct = 0; stall_pct = 0;
		hold_req <= 1'b1;
		run_random(140);
		setup(7'd20, 48'd0, 1'b1, 32'd0, 1'b0, 32'd0);
		idle_pct = 21; stall_pct = 21;
		run_random(40);
		setup(7'd10, 48'd30000, 1'b0, 32'd100, 1'b0, 32'd1);
		run_random(100);

		drain();
		if (sb.errors == 0)
			$display("** adaptive_garbage_collection_trigger_top: PASSED **");
		else
			$display("** adaptive_garbage_collection_trigger_top: FAILED **");
		$finish;
	end
endmodule
